// ----- hw/rtl/ckore_pkg.sv -----
// Shared types and constants of the colour-key opaque run extractor.
`default_nettype none
package ckore_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CfgOriginX     = 3'd0;
    localparam logic [2:0] CfgOriginY     = 3'd1;
    localparam logic [2:0] CfgImageWidth  = 3'd2;
    localparam logic [2:0] CfgImageHeight = 3'd3;
    localparam logic [2:0] CfgKeyRed      = 3'd4;
    localparam logic [2:0] CfgKeyGreen    = 3'd5;
    localparam logic [2:0] CfgKeyBlue     = 3'd6;

    // Register reset values.
    localparam logic [8:0] RstOriginX     = 9'd0;
    localparam logic [8:0] RstOriginY     = 9'd0;
    localparam logic [9:0] RstImageWidth  = 10'd480;
    localparam logic [9:0] RstImageHeight = 10'd320;
    localparam logic [7:0] RstKeyRed      = 8'hFF;
    localparam logic [7:0] RstKeyGreen    = 8'h00;
    localparam logic [7:0] RstKeyBlue     = 8'hFF;

    // Result queue between the classifier and the output stage.
    localparam int unsigned QDepth   = 4;
    localparam int unsigned QPtrW    = $clog2(QDepth);
    localparam int unsigned QCountW  = $clog2(QDepth + 1);

    typedef struct packed {
        logic [8:0] origin_x;
        logic [8:0] origin_y;
        logic [9:0] image_width;
        logic [9:0] image_height;
        logic [7:0] key_red;
        logic [7:0] key_green;
        logic [7:0] key_blue;
    } t_cfg;

    typedef struct packed {
        logic [8:0] screen_x;
        logic [8:0] screen_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] run_start_x;
        logic       run_last;
    } t_result;

    // Pushes from the classifier: the released held pixel and the current pixel.
    typedef struct packed {
        logic held;
        logic curr;
    } t_push;

endpackage
`default_nettype wire

// ----- hw/rtl/ckore_front.sv -----
// Classifier: window clipping, key compare, run tracking and the held pixel.
`default_nettype none
module ckore_front #(
    parameter int SCREEN_WIDTH  = 480,
    parameter int SCREEN_HEIGHT = 320
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ckore_pkg::t_cfg   i_cfg,
    input  wire logic              i_valid,
    input  wire logic              i_frame_start,
    input  wire logic [7:0]        i_pix_red,
    input  wire logic [7:0]        i_pix_green,
    input  wire logic [7:0]        i_pix_blue,
    input  wire logic              i_room,
    output logic                   o_accept,
    output ckore_pkg::t_push       o_push,
    output ckore_pkg::t_result     o_held_res,
    output ckore_pkg::t_result     o_curr_res
);

    localparam int SwBits = $clog2(SCREEN_WIDTH + 1);
    localparam int ShBits = $clog2(SCREEN_HEIGHT + 1);
    localparam int DimW0  = (SwBits > ShBits) ? SwBits : ShBits;
    localparam int DimW   = (DimW0 > 10) ? DimW0 : 10;
    localparam logic [DimW-1:0] ScrW = DimW'(SCREEN_WIDTH);
    localparam logic [DimW-1:0] ScrH = DimW'(SCREEN_HEIGHT);

    logic [9:0]  r_col, n_col;
    logic [9:0]  r_row, n_row;
    logic        r_held_valid, n_held_valid;
    logic [23:0] r_held_color, n_held_color;
    logic [8:0]  r_held_col, n_held_col;
    logic [8:0]  r_run_start, n_run_start;

    logic            off_screen;
    logic [DimW-1:0] room_x, room_y;
    logic [9:0]      win_w, win_h;
    logic [9:0]      eff_col, eff_row;
    logic            outside, is_key, opaque_in, held_eff, at_edge;
    logic [10:0]     col_inc;
    logic [8:0]      run_col_curr;

    assign o_accept = i_valid && i_room;

    always_comb begin
        off_screen = (DimW'(i_cfg.origin_x) >= ScrW) || (DimW'(i_cfg.origin_y) >= ScrH);
        room_x     = ScrW - DimW'(i_cfg.origin_x);
        room_y     = ScrH - DimW'(i_cfg.origin_y);
        win_w      = (DimW'(i_cfg.image_width) < room_x) ? i_cfg.image_width : room_x[9:0];
        win_h      = (DimW'(i_cfg.image_height) < room_y) ? i_cfg.image_height : room_y[9:0];
        eff_col    = i_frame_start ? 10'd0 : r_col;
        eff_row    = i_frame_start ? 10'd0 : r_row;
        outside    = (eff_row >= win_h) || (eff_col >= win_w);
        is_key     = (i_pix_red == i_cfg.key_red) && (i_pix_green == i_cfg.key_green)
                     && (i_pix_blue == i_cfg.key_blue);
        opaque_in  = !outside && !is_key;
        held_eff   = r_held_valid && !i_frame_start;
        col_inc    = {1'b0, eff_col} + 11'd1;
        at_edge    = col_inc >= {1'b0, win_w};
        run_col_curr = held_eff ? r_run_start : eff_col[8:0];
    end

    always_comb begin
        o_push.held = o_accept && !off_screen && r_held_valid;
        o_push.curr = o_accept && !off_screen && opaque_in && at_edge;

        // The held pixel takes the row count from before any restart.
        o_held_res.screen_x    = i_cfg.origin_x + r_held_col;
        o_held_res.screen_y    = i_cfg.origin_y + r_row[8:0];
        o_held_res.red         = r_held_color[23:16];
        o_held_res.green       = r_held_color[15:8];
        o_held_res.blue        = r_held_color[7:0];
        o_held_res.run_start_x = i_cfg.origin_x + r_run_start;
        o_held_res.run_last    = i_frame_start || !opaque_in;

        o_curr_res.screen_x    = i_cfg.origin_x + eff_col[8:0];
        o_curr_res.screen_y    = i_cfg.origin_y + eff_row[8:0];
        o_curr_res.red         = i_pix_red;
        o_curr_res.green       = i_pix_green;
        o_curr_res.blue        = i_pix_blue;
        o_curr_res.run_start_x = i_cfg.origin_x + run_col_curr;
        o_curr_res.run_last    = 1'b1;
    end

    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_held_valid = r_held_valid;
        n_held_color = r_held_color;
        n_held_col   = r_held_col;
        n_run_start  = r_run_start;
        if (o_accept) begin
            if (off_screen) begin
                n_held_valid = 1'b0;
                n_col        = eff_col;
                n_row        = eff_row;
            end else begin
                n_held_valid = opaque_in && !at_edge;
                if (opaque_in) begin
                    n_held_color = {i_pix_red, i_pix_green, i_pix_blue};
                    n_held_col   = eff_col[8:0];
                    if (!held_eff) begin
                        n_run_start = eff_col[8:0];
                    end
                end
                if (outside) begin
                    if (eff_row < win_h) begin
                        n_col = 10'd0;
                        n_row = eff_row + 10'd1;
                    end else begin
                        n_col = eff_col;
                        n_row = eff_row;
                    end
                end else if (at_edge) begin
                    n_col = 10'd0;
                    n_row = eff_row + 10'd1;
                end else begin
                    n_col = col_inc[9:0];
                    n_row = eff_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_held_valid <= 1'b0;
            r_held_color <= '0;
            r_held_col   <= '0;
            r_run_start  <= '0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_held_valid <= n_held_valid;
            r_held_color <= n_held_color;
            r_held_col   <= n_held_col;
            r_run_start  <= n_run_start;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ckore_queue.sv -----
// Short result queue taking up to two results and giving one per cycle while the output stage pops.
`default_nettype none
module ckore_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ckore_pkg::t_push    i_push,
    input  wire ckore_pkg::t_result  i_held_res,
    input  wire ckore_pkg::t_result  i_curr_res,
    input  wire logic                i_pop,
    output logic                     o_room,
    output logic                     o_not_empty,
    output ckore_pkg::t_result       o_head
);

    ckore_pkg::t_result r_mem [ckore_pkg::QDepth];
    logic [ckore_pkg::QPtrW-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [ckore_pkg::QCountW-1:0] r_count, n_count;
    logic [ckore_pkg::QCountW-1:0] push_n;
    logic [ckore_pkg::QPtrW-1:0]   wr_next;
    ckore_pkg::t_result            first_res;

    always_comb begin
        push_n    = ckore_pkg::QCountW'(i_push.held) + ckore_pkg::QCountW'(i_push.curr);
        wr_next   = r_wr + ckore_pkg::QPtrW'(1);
        first_res = i_push.held ? i_held_res : i_curr_res;
        n_wr      = r_wr + push_n[ckore_pkg::QPtrW-1:0];
        n_rd      = i_pop ? r_rd + ckore_pkg::QPtrW'(1) : r_rd;
        n_count   = r_count + push_n - ckore_pkg::QCountW'(i_pop);
    end

    // Room for two more is kept so that any item can be taken.
    assign o_room      = r_count <= ckore_pkg::QCountW'(ckore_pkg::QDepth - 2);
    assign o_not_empty = r_count != '0;
    assign o_head      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.held || i_push.curr) begin
            r_mem[r_wr] <= first_res;
        end
        if (i_push.held && i_push.curr) begin
            r_mem[wr_next] <= i_curr_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ckore_pkg::QCountW'(ckore_pkg::QDepth))
        else $error("result queue count exceeds its depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.held || i_push.curr) |-> o_room)
        else $error("result pushed while the queue lacks room");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("result popped from an empty queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == r_count[ckore_pkg::QPtrW-1:0])
        else $error("queue pointers disagree with the count");

endmodule
`default_nettype wire

// ----- hw/rtl/ckore_back.sv -----
// Output register stage draining the result queue.
`default_nettype none
module ckore_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_not_empty,
    input  wire ckore_pkg::t_result  i_head,
    input  wire logic                i_stall,
    output logic                     o_pop,
    output logic                     o_valid,
    output ckore_pkg::t_result       o_res
);

    logic               r_valid;
    ckore_pkg::t_result r_res;
    logic               load_en;

    assign load_en = !r_valid || !i_stall;
    assign o_pop   = load_en && i_not_empty;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_en) begin
            r_valid <= i_not_empty;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/color_key_opaque_run_extractor_unit.sv -----
// Top level of the colour-key opaque run extractor.
// Usage: pixels of an image window arrive in raster order on the input channel
// (i_valid, o_stall, i_frame_start and the three colour bytes); a transaction
// completes at a rising edge with i_valid high and o_stall low. Opaque pixels
// leave on the output channel (o_valid, i_stall) with their screen position,
// colour, the column where their run began and a flag on the last of the run.
// Pixels matching the key colour, and pixels outside the clipped window, give
// no output. One opaque pixel is held back until the next pixel shows whether
// its run has ended, so most outputs are caused by the following transaction.
// Flow: a result is written into the queue at the edge that accepts the input
// transaction and moves on to the output register once that register is free;
// a second result from the same transaction follows it. Throughput: one input
// transaction per cycle while o_stall is low; an input may cause two results,
// and the output side delivers one per cycle while i_stall is low, which the
// four-entry result queue between classifier and output absorbs.
// o_stall rises only when the queue has fewer than two free entries.
// Reset (synchronous, active low) empties the queue and the output register,
// clears the position counters and the held pixel, and loads the register
// defaults. A stalled output holds its result; the queue then fills and the
// input side stalls in turn. Configuration writes take effect at once; the user
// must make them only while the block is idle; the block does not enforce this.
`default_nettype none
module color_key_opaque_run_extractor_unit #(
    parameter int SCREEN_WIDTH  = 480,
    parameter int SCREEN_HEIGHT = 320
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write port.
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [9:0] i_cfg_data,
    // Pixel input channel.
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_frame_start,
    input  wire logic [7:0] i_pix_red,
    input  wire logic [7:0] i_pix_green,
    input  wire logic [7:0] i_pix_blue,
    // Result output channel.
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [8:0]      o_screen_x,
    output logic [8:0]      o_screen_y,
    output logic [7:0]      o_out_red,
    output logic [7:0]      o_out_green,
    output logic [7:0]      o_out_blue,
    output logic [8:0]      o_run_start_x,
    output logic            o_run_last
);

    ckore_pkg::t_cfg    r_cfg;
    ckore_pkg::t_push   push;
    ckore_pkg::t_result held_res, curr_res, head, out_res;
    logic               room, accept, not_empty, pop;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x     <= ckore_pkg::RstOriginX;
            r_cfg.origin_y     <= ckore_pkg::RstOriginY;
            r_cfg.image_width  <= ckore_pkg::RstImageWidth;
            r_cfg.image_height <= ckore_pkg::RstImageHeight;
            r_cfg.key_red      <= ckore_pkg::RstKeyRed;
            r_cfg.key_green    <= ckore_pkg::RstKeyGreen;
            r_cfg.key_blue     <= ckore_pkg::RstKeyBlue;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ckore_pkg::CfgOriginX:     r_cfg.origin_x     <= i_cfg_data[8:0];
                ckore_pkg::CfgOriginY:     r_cfg.origin_y     <= i_cfg_data[8:0];
                ckore_pkg::CfgImageWidth:  r_cfg.image_width  <= i_cfg_data;
                ckore_pkg::CfgImageHeight: r_cfg.image_height <= i_cfg_data;
                ckore_pkg::CfgKeyRed:      r_cfg.key_red      <= i_cfg_data[7:0];
                ckore_pkg::CfgKeyGreen:    r_cfg.key_green    <= i_cfg_data[7:0];
                ckore_pkg::CfgKeyBlue:     r_cfg.key_blue     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // The classifier takes a pixel whenever the queue can hold two results.
    ckore_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .i_frame_start(i_frame_start),
        .i_pix_red    (i_pix_red),
        .i_pix_green  (i_pix_green),
        .i_pix_blue   (i_pix_blue),
        .i_room       (room),
        .o_accept     (accept),
        .o_push       (push),
        .o_held_res   (held_res),
        .o_curr_res   (curr_res)
    );

    ckore_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_held_res (held_res),
        .i_curr_res (curr_res),
        .i_pop      (pop),
        .o_room     (room),
        .o_not_empty(not_empty),
        .o_head     (head)
    );

    ckore_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_not_empty(not_empty),
        .i_head     (head),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_res      (out_res)
    );

    assign o_stall       = !room;
    assign o_screen_x    = out_res.screen_x;
    assign o_screen_y    = out_res.screen_y;
    assign o_out_red     = out_res.red;
    assign o_out_green   = out_res.green;
    assign o_out_blue    = out_res.blue;
    assign o_run_start_x = out_res.run_start_x;
    assign o_run_last    = out_res.run_last;

    // A pushed result only ever comes from an accepted transaction.
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.held || push.curr) |-> accept)
        else $error("result pushed without an accepted transaction");

    // The current pixel is only pushed as the end of its run.
    a_curr_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.curr |-> curr_res.run_last)
        else $error("current pixel pushed without the run end flag");

    // An output result that is not taken is not reloaded and stays valid.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> (!pop ##1 o_valid))
        else $error("stalled output register was reloaded");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the colour-key opaque run extractor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    // The screen size that the block is built for.
    localparam int ScreenW = 480;
    localparam int ScreenH = 320;
    // Cycles to let pass once nothing is expected any more, enough to cover the
    // queue and the output register with room to spare.
    localparam int SettleCycles = 8;
    // Number of random phases and the number of pixel transactions in each.
    localparam int RandomPhases = 40;
    localparam int PhaseBudget  = 47;

    // One pixel transaction as it is presented on the input channel.
    typedef struct packed {
        logic       frame_start;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_pixel;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic [2:0] i_cfg_idx     = ckore_pkg::CfgOriginX;
    logic [9:0] i_cfg_data    = '0;
    logic       i_valid       = 1'b0;
    logic       o_stall;
    logic       i_frame_start = 1'b0;
    logic [7:0] i_pix_red     = '0;
    logic [7:0] i_pix_green   = '0;
    logic [7:0] i_pix_blue    = '0;
    logic       o_valid;
    logic       i_stall       = 1'b0;
    logic [8:0] o_screen_x;
    logic [8:0] o_screen_y;
    logic [7:0] o_out_red;
    logic [7:0] o_out_green;
    logic [7:0] o_out_blue;
    logic [8:0] o_run_start_x;
    logic       o_run_last;

    color_key_opaque_run_extractor_unit #(
        .SCREEN_WIDTH (ScreenW),
        .SCREEN_HEIGHT(ScreenH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_frame_start(i_frame_start),
        .i_pix_red    (i_pix_red),
        .i_pix_green  (i_pix_green),
        .i_pix_blue   (i_pix_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_run_start_x(o_run_start_x),
        .o_run_last   (o_run_last)
    );

    always #5 i_clk = ~i_clk;

    // Pixels waiting to be driven, and the opaque pixels that the block owes us,
    // oldest first.
    t_rgb_pixel          pixel_stream_q[$];
    ckore_pkg::t_result  opaque_pixels_q[$];

    // Idling of either side, in percent of cycles; set per phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // Shadow of the configuration registers, kept in step with every write.
    ckore_pkg::t_cfg cfg_shadow = '{
        origin_x:     ckore_pkg::RstOriginX,
        origin_y:     ckore_pkg::RstOriginY,
        image_width:  ckore_pkg::RstImageWidth,
        image_height: ckore_pkg::RstImageHeight,
        key_red:      ckore_pkg::RstKeyRed,
        key_green:    ckore_pkg::RstKeyGreen,
        key_blue:     ckore_pkg::RstKeyBlue
    };

    // Predictor state: where the next pixel falls in the window, and the one
    // opaque pixel held back until we know whether its run goes on.
    int          next_col      = 0;
    int          next_row      = 0;
    logic        hold_live     = 1'b0;
    logic [23:0] hold_rgb      = '0;
    int          hold_col      = 0;
    int          run_first_col = 0;

    // The window after clipping to the screen. Only meaningful while the origin
    // lies on the screen.
    function automatic void clip_window(output int w, output int h);
        w = ScreenW - int'(cfg_shadow.origin_x);
        if (int'(cfg_shadow.image_width) < w) begin
            w = int'(cfg_shadow.image_width);
        end
        h = ScreenH - int'(cfg_shadow.origin_y);
        if (int'(cfg_shadow.image_height) < h) begin
            h = int'(cfg_shadow.image_height);
        end
    endfunction

    // Screen coordinates are formed from the registers as they stand when the
    // pixel leaves, not when it arrived.
    task automatic owe_pixel(input int col, input int row, input logic [23:0] rgb,
                             input int run_col, input logic last);
        ckore_pkg::t_result res;
        int      sx;
        int      sy;
        int      rx;
        sx = int'(cfg_shadow.origin_x) + col;
        sy = int'(cfg_shadow.origin_y) + row;
        rx = int'(cfg_shadow.origin_x) + run_col;
        res.screen_x    = sx[8:0];
        res.screen_y    = sy[8:0];
        res.red         = rgb[23:16];
        res.green       = rgb[15:8];
        res.blue        = rgb[7:0];
        res.run_start_x = rx[8:0];
        res.run_last    = last;
        opaque_pixels_q.push_back(res);
    endtask

    task automatic release_hold(input logic last);
        if (hold_live) begin
            owe_pixel(hold_col, next_row, hold_rgb, run_first_col, last);
            hold_live = 1'b0;
        end
    endtask

    // Works out what one accepted pixel makes the block emit. The held pixel,
    // when released, always comes out ahead of the current one.
    task automatic predict_pixel(input logic start, input logic [23:0] rgb);
        int w;
        int h;
        int c;
        if (int'(cfg_shadow.origin_x) >= ScreenW || int'(cfg_shadow.origin_y) >= ScreenH) begin
            // Origin off the screen: everything is swallowed, the held pixel is
            // lost, and only a frame start touches the position.
            hold_live = 1'b0;
            if (start) begin
                next_col = 0;
                next_row = 0;
            end
        end else begin
            if (start) begin
                // The held pixel closes its run using the row from before the restart.
                release_hold(1'b1);
                next_col = 0;
                next_row = 0;
            end
            clip_window(w, h);
            if (next_row >= h || next_col >= w) begin
                // Beyond the last row, or beyond a width that shrank mid-image.
                release_hold(1'b1);
                if (next_row < h) begin
                    next_col = 0;
                    next_row++;
                end
            end else begin
                c = next_col;
                if (rgb == {cfg_shadow.key_red, cfg_shadow.key_green, cfg_shadow.key_blue}) begin
                    release_hold(1'b1);
                end else begin
                    if (hold_live) begin
                        release_hold(1'b0);
                    end else begin
                        run_first_col = c;
                    end
                    if (c + 1 >= w) begin
                        // Right edge: the pixel closes its run straight away.
                        owe_pixel(c, next_row, rgb, run_first_col, 1'b1);
                    end else begin
                        hold_live = 1'b1;
                        hold_rgb  = rgb;
                        hold_col  = c;
                    end
                end
                if (c + 1 >= w) begin
                    next_col = 0;
                    next_row++;
                end else begin
                    next_col = c + 1;
                end
            end
        end
    endtask

    // Input driver. A transaction completes at an edge with i_valid high and
    // o_stall low; the payload is held unchanged for as long as it is stalled.
    always @(posedge i_clk) begin : pixel_driver
        t_rgb_pixel nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_pixel(i_frame_start, {i_pix_red, i_pix_green, i_pix_blue});
            end
            if (!i_valid || !o_stall) begin
                if (pixel_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pixel_stream_q.pop_front();
                    i_valid       <= 1'b1;
                    i_frame_start <= nxt.frame_start;
                    i_pix_red     <= nxt.red;
                    i_pix_green   <= nxt.green;
                    i_pix_blue    <= nxt.blue;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Output monitor: every result transaction is matched against the oldest
    // owed pixel, field by field. The stall is drawn afresh each cycle.
    always @(posedge i_clk) begin : result_monitor
        ckore_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (opaque_pixels_q.size() == 0) begin
                    $display("%0t ns: no result expected, actual x=%0d y=%0d rgb=%02h%02h%02h",
                             $time, o_screen_x, o_screen_y, o_out_red, o_out_green,
                             o_out_blue);
                    mismatch_count++;
                end else begin
                    want = opaque_pixels_q.pop_front();
                    check_field("screen_x", int'(want.screen_x), int'(o_screen_x));
                    check_field("screen_y", int'(want.screen_y), int'(o_screen_y));
                    check_field("out_red", int'(want.red), int'(o_out_red));
                    check_field("out_green", int'(want.green), int'(o_out_green));
                    check_field("out_blue", int'(want.blue), int'(o_out_blue));
                    check_field("run_start_x", int'(want.run_start_x),
                                int'(o_run_start_x));
                    check_field("run_last", int'(want.run_last), int'(o_run_last));
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Register writes are only issued with the block idle, so the shadow can be
    // updated at once.
    task automatic write_reg(input logic [2:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[9:0];
        case (idx)
            ckore_pkg::CfgOriginX:     cfg_shadow.origin_x     = val[8:0];
            ckore_pkg::CfgOriginY:     cfg_shadow.origin_y     = val[8:0];
            ckore_pkg::CfgImageWidth:  cfg_shadow.image_width  = val[9:0];
            ckore_pkg::CfgImageHeight: cfg_shadow.image_height = val[9:0];
            ckore_pkg::CfgKeyRed:      cfg_shadow.key_red      = val[7:0];
            ckore_pkg::CfgKeyGreen:    cfg_shadow.key_green    = val[7:0];
            ckore_pkg::CfgKeyBlue:     cfg_shadow.key_blue     = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued pixel has gone in and every owed result has come
    // out, then lets the pipeline settle. A pixel that only refills the hold
    // owes nothing, so the settling time matters before the next write.
    task automatic wait_until_drained();
        while (pixel_stream_q.size() != 0 || i_valid || opaque_pixels_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic push_pixel(input logic start, input logic [23:0] rgb);
        pixel_stream_q.push_back({start, rgb});
    endtask

    // Random pixel content: the key colour often enough to break rows into
    // runs, colours one bit away from the key to exercise each comparator bit,
    // and fully random colours.
    function automatic logic [23:0] random_rgb();
        logic [23:0] key;
        logic [23:0] one_hot;
        logic [31:0] rnd;
        logic [4:0]  bit_sel;
        int          sel;
        key = {cfg_shadow.key_red, cfg_shadow.key_green, cfg_shadow.key_blue};
        sel = $urandom_range(99);
        rnd = $urandom;
        one_hot = '0;
        bit_sel = 5'($urandom_range(23));
        one_hot[bit_sel] = 1'b1;
        if (sel < 40) begin
            return key;
        end else if (sel < 50) begin
            return key ^ one_hot;
        end
        return rnd[23:0];
    endfunction

    // Mostly whole frames of the current window, most opened with a frame
    // start, with a few stray pixels past the end and the odd restart mid-frame.
    task automatic queue_phase_pixels(input int budget);
        int   w;
        int   h;
        int   n;
        logic start;
        clip_window(w, h);
        while (budget > 0) begin
            if (int'(cfg_shadow.origin_x) >= ScreenW || int'(cfg_shadow.origin_y) >= ScreenH ||
                w <= 0 || h <= 0) begin
                n = 6;
            end else begin
                n = w * h + $urandom_range(0, 2);
            end
            if (n > budget) begin
                n = budget;
            end
            start = ($urandom_range(99) < 85);
            for (int i = 0; i < n; i++) begin
                push_pixel((i == 0) ? start : ($urandom_range(99) < 2), random_rgb());
            end
            budget -= n;
        end
    endtask

    // A fresh setting: each register is rewritten or left alone, so that a
    // held pixel and the position sometimes carry over into the new setting.
    task automatic pick_config();
        if ($urandom_range(99) < 70) begin
            case ($urandom_range(11))
                0:       write_reg(ckore_pkg::CfgOriginX, 0);
                1:       write_reg(ckore_pkg::CfgOriginX, ScreenW - 1);
                2:       write_reg(ckore_pkg::CfgOriginX, $urandom_range(ScreenW, 511));
                3:       write_reg(ckore_pkg::CfgOriginX,
                                   $urandom_range(ScreenW - 10, ScreenW - 1));
                default: write_reg(ckore_pkg::CfgOriginX, $urandom_range(0, ScreenW - 1));
            endcase
        end
        if ($urandom_range(99) < 70) begin
            case ($urandom_range(11))
                0:       write_reg(ckore_pkg::CfgOriginY, 0);
                1:       write_reg(ckore_pkg::CfgOriginY, ScreenH - 1);
                2:       write_reg(ckore_pkg::CfgOriginY, $urandom_range(ScreenH, 511));
                3:       write_reg(ckore_pkg::CfgOriginY,
                                   $urandom_range(ScreenH - 6, ScreenH - 1));
                default: write_reg(ckore_pkg::CfgOriginY, $urandom_range(0, ScreenH - 1));
            endcase
        end
        if ($urandom_range(99) < 70) begin
            case ($urandom_range(9))
                0:       write_reg(ckore_pkg::CfgImageWidth, 0);
                1:       write_reg(ckore_pkg::CfgImageWidth, 512);
                2:       write_reg(ckore_pkg::CfgImageWidth, ScreenW);
                default: write_reg(ckore_pkg::CfgImageWidth, $urandom_range(1, 12));
            endcase
        end
        if ($urandom_range(99) < 70) begin
            case ($urandom_range(9))
                0:       write_reg(ckore_pkg::CfgImageHeight, 0);
                1:       write_reg(ckore_pkg::CfgImageHeight, 512);
                default: write_reg(ckore_pkg::CfgImageHeight, $urandom_range(1, 6));
            endcase
        end
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(1) == 1) begin
                case ($urandom_range(3))
                    0:       write_reg(ckore_pkg::CfgKeyRed + 3'(k), 0);
                    1:       write_reg(ckore_pkg::CfgKeyRed + 3'(k), 255);
                    default: write_reg(ckore_pkg::CfgKeyRed + 3'(k), $urandom_range(0, 255));
                endcase
            end
        end
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a 4 x 2 window clipped against the bottom right corner
        // of the screen, so that coordinates reach their largest values.
        write_reg(ckore_pkg::CfgOriginX, 476);
        write_reg(ckore_pkg::CfgOriginY, 318);
        write_reg(ckore_pkg::CfgImageWidth, 512);
        write_reg(ckore_pkg::CfgImageHeight, 512);
        write_reg(ckore_pkg::CfgKeyRed, 'h12);
        write_reg(ckore_pkg::CfgKeyGreen, 'h34);
        write_reg(ckore_pkg::CfgKeyBlue, 'h56);
        push_pixel(1'b1, 24'hFFFFFF);
        push_pixel(1'b0, 24'h000000);
        push_pixel(1'b0, 24'h123456);  // key colour ends the run
        push_pixel(1'b0, 24'h123457);  // lone pixel at the right edge
        push_pixel(1'b0, 24'h123456);
        push_pixel(1'b0, 24'h133456);
        push_pixel(1'b0, 24'h123476);
        push_pixel(1'b0, 24'h800001);  // releases the hold and closes at the edge
        push_pixel(1'b0, 24'hAA55AA);  // after the last row
        push_pixel(1'b1, 24'h010203);
        push_pixel(1'b0, 24'h123456);
        push_pixel(1'b0, 24'h123456);
        push_pixel(1'b0, 24'h123456);
        push_pixel(1'b0, 24'h7F7F7F);
        push_pixel(1'b1, 24'hFEDCBA);  // frame start with a pixel held in row one
        push_pixel(1'b0, 24'h00FF00);
        wait_until_drained();

        // Origin off the screen on either axis drops the held pixel silently.
        write_reg(ckore_pkg::CfgOriginX, 511);
        push_pixel(1'b0, 24'h000000);
        push_pixel(1'b1, 24'hFFFFFF);
        wait_until_drained();
        write_reg(ckore_pkg::CfgOriginX, 0);
        write_reg(ckore_pkg::CfgOriginY, ScreenH);
        push_pixel(1'b1, 24'h111111);
        wait_until_drained();

        // An empty window, then a width that shrinks under a held pixel.
        write_reg(ckore_pkg::CfgOriginY, 0);
        write_reg(ckore_pkg::CfgImageWidth, 0);
        push_pixel(1'b1, 24'h222222);
        push_pixel(1'b0, 24'h333333);
        wait_until_drained();
        write_reg(ckore_pkg::CfgImageWidth, 3);
        write_reg(ckore_pkg::CfgImageHeight, 1);
        push_pixel(1'b1, 24'h444444);
        wait_until_drained();
        write_reg(ckore_pkg::CfgImageWidth, 1);
        push_pixel(1'b0, 24'h555555);
        push_pixel(1'b0, 24'h666666);
        wait_until_drained();

        // Random part, cycling through the idling patterns of the two sides.
        for (int p = 0; p < RandomPhases; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            pick_config();
            queue_phase_pixels(PhaseBudget);
            wait_until_drained();
        end

        if (mismatch_count == 0 && opaque_pixels_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin : watchdog
        #5000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
